>>> design/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// shared types and constants for the bearing-to-point unit
// ----------------------------------------------------------------------------
package btp_pkg;

   localparam int BEARING_W = 15;
   localparam int ANGLE_W   = 14;
   localparam int FOLD_W    = 16;
   localparam int ZW        = 31;
   localparam int ZTAB_W    = 29;
   localparam int Z_FRAC    = 16;
   localparam int MAX_STAGES = 32;

   localparam logic [FOLD_W-1:0] DEG0   = 16'd0;
   localparam logic [FOLD_W-1:0] DEG90  = 16'd5760;
   localparam logic [FOLD_W-1:0] DEG180 = 16'd11520;
   localparam logic [FOLD_W-1:0] DEG270 = 16'd17280;
   localparam logic [FOLD_W-1:0] DEG360 = 16'd23040;

   localparam logic [ZTAB_W-1:0] Z_DEG90 = 29'd377487360;
   localparam logic [ZTAB_W:0]   Z_HALF  = 30'd32768;

   localparam logic [ZTAB_W-1:0] ATAN_TAB [MAX_STAGES] = '{
      29'd188743680, 29'd111421900, 29'd58872272, 29'd29884485,
      29'd15000234,  29'd7507429,   29'd3754631,  29'd1877430,
      29'd938729,    29'd469366,    29'd234683,   29'd117342,
      29'd58671,     29'd29335,     29'd14668,    29'd7334,
      29'd3667,      29'd1833,      29'd917,      29'd458,
      29'd229,       29'd115,       29'd57,       29'd29,
      29'd14,        29'd7,         29'd4,        29'd2,
      29'd1,         29'd0,         29'd0,        29'd0
   };

   typedef struct packed {
      logic                 axis;
      logic                 pts_differ;
      logic                 neg_x;
      logic                 neg_y;
      logic [BEARING_W-1:0] axis_bearing;
   } btp_side_type;

endpackage

>>> design/btp_channels.sv
// ----------------------------------------------------------------------------
// btp channels
// request and response channel interfaces of the bearing-to-point unit
// ----------------------------------------------------------------------------
interface btp_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] cur_x;
   logic signed [COORD_WIDTH-1:0] cur_y;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_y;

   modport source (output valid, cur_x, cur_y, target_x, target_y, input ready);
   modport sink   (input valid, cur_x, cur_y, target_x, target_y, output ready);
endinterface

interface btp_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] bearing;
   logic        bearing_valid;

   modport source (output valid, bearing, bearing_valid, input ready);
   modport sink   (input valid, bearing, bearing_valid, output ready);
endinterface

>>> design/btp_front.sv
// ----------------------------------------------------------------------------
// btp_front
// difference vector, magnitudes, quadrant and axis classification
// ----------------------------------------------------------------------------
module btp_front import btp_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int DW          = 35
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_up,
   output logic                          ready_up,
   input  logic signed [COORD_WIDTH-1:0] cur_x,
   input  logic signed [COORD_WIDTH-1:0] cur_y,
   input  logic signed [COORD_WIDTH-1:0] target_x,
   input  logic signed [COORD_WIDTH-1:0] target_y,
   output logic                          valid_dn,
   input  logic                          ready_dn,
   output logic signed [DW-1:0]          x_dn,
   output logic signed [DW-1:0]          y_dn,
   output btp_side_type                  side_dn
);

   localparam int PAD = DW - COORD_WIDTH - 1 - Z_FRAC;

   logic signed [COORD_WIDTH:0] dx, dy;
   logic [COORD_WIDTH:0]        abs_x, abs_y;
   logic                        valid_ff;
   logic signed [DW-1:0]        x_ff, y_ff, x_in, y_in;
   btp_side_type                side_ff, side_in;

   assign dx = {target_x[COORD_WIDTH-1], target_x} - {cur_x[COORD_WIDTH-1], cur_x};
   assign dy = {target_y[COORD_WIDTH-1], target_y} - {cur_y[COORD_WIDTH-1], cur_y};
   assign abs_x = dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
   assign abs_y = dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);
   assign x_in = $signed({{PAD{1'b0}}, abs_x, {Z_FRAC{1'b0}}});
   assign y_in = $signed({{PAD{1'b0}}, abs_y, {Z_FRAC{1'b0}}});

   always_comb begin
      side_in.neg_x        = dx[COORD_WIDTH];
      side_in.neg_y        = dy[COORD_WIDTH];
      side_in.axis         = (dx == '0) || (dy == '0);
      side_in.pts_differ   = (dx != '0) || (dy != '0);
      side_in.axis_bearing = '0;
      if (dx == '0 && dy == '0) begin
         side_in.axis_bearing = DEG0[BEARING_W-1:0];
      end else if (dy == '0) begin
         side_in.axis_bearing = dx[COORD_WIDTH] ? DEG180[BEARING_W-1:0] : DEG0[BEARING_W-1:0];
      end else if (dx == '0) begin
         side_in.axis_bearing = dy[COORD_WIDTH] ? DEG270[BEARING_W-1:0] : DEG90[BEARING_W-1:0];
      end
   end

   assign ready_up = ~valid_ff | ready_dn;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up && valid_up) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         side_ff <= side_in;
      end
   end

   assign valid_dn = valid_ff;
   assign x_dn     = x_ff;
   assign y_dn     = y_ff;
   assign side_dn  = side_ff;

endmodule

>>> design/btp_cell.sv
// ----------------------------------------------------------------------------
// btp_cell
// one cordic vectoring rotation with its own handshake slot
// ----------------------------------------------------------------------------
module btp_cell import btp_pkg::*; #(
   parameter int DW    = 35,
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_up,
   output logic                 ready_up,
   input  logic signed [DW-1:0] x_up,
   input  logic signed [DW-1:0] y_up,
   input  logic signed [ZW-1:0] z_up,
   input  btp_side_type         side_up,
   output logic                 valid_dn,
   input  logic                 ready_dn,
   output logic signed [DW-1:0] x_dn,
   output logic signed [DW-1:0] y_dn,
   output logic signed [ZW-1:0] z_dn,
   output btp_side_type         side_dn
);

   localparam logic signed [ZW-1:0] STEP = $signed({{(ZW-ZTAB_W){1'b0}}, ATAN_TAB[STAGE]});

   logic signed [DW-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0] z_in, z_ff;
   btp_side_type         side_ff;
   logic                 valid_ff;

   assign xs = x_up >>> STAGE;
   assign ys = y_up >>> STAGE;

   always_comb begin
      if (!y_up[DW-1]) begin
         x_in = x_up + ys;
         y_in = y_up - xs;
         z_in = z_up + STEP;
      end else begin
         x_in = x_up - ys;
         y_in = y_up + xs;
         z_in = z_up - STEP;
      end
   end

   assign ready_up = ~valid_ff | ready_dn;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up && valid_up) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_up;
      end
   end

   assign valid_dn = valid_ff;
   assign x_dn     = x_ff;
   assign y_dn     = y_ff;
   assign z_dn     = z_ff;
   assign side_dn  = side_ff;

endmodule

>>> design/btp_back.sv
// ----------------------------------------------------------------------------
// btp_back
// angle clamp and rounding, quadrant fold, response register
// ----------------------------------------------------------------------------
module btp_back import btp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_up,
   output logic                 ready_up,
   input  logic signed [ZW-1:0] z_up,
   input  btp_side_type         side_up,
   output logic                 valid_dn,
   input  logic                 ready_dn,
   output logic [BEARING_W-1:0] bearing,
   output logic                 bearing_valid
);

   logic [ZTAB_W-1:0]    z_clamp;
   logic [ZTAB_W:0]      z_round;
   logic [FOLD_W-1:0]    angle, fold, wrap;
   logic                 valid_ff;
   logic [BEARING_W-1:0] bearing_ff, bearing_in;
   logic                 bvalid_ff;

   always_comb begin
      if (z_up[ZW-1]) begin
         z_clamp = '0;
      end else if ($unsigned(z_up) > {{(ZW-ZTAB_W){1'b0}}, Z_DEG90}) begin
         z_clamp = Z_DEG90;
      end else begin
         z_clamp = z_up[ZTAB_W-1:0];
      end
   end

   assign z_round = {1'b0, z_clamp} + Z_HALF;
   assign angle   = {{(FOLD_W-ANGLE_W){1'b0}}, z_round[Z_FRAC +: ANGLE_W]};

   always_comb begin
      case ({side_up.neg_x, side_up.neg_y})
         2'b00:   fold = angle;
         2'b10:   fold = DEG180 - angle;
         2'b11:   fold = DEG180 + angle;
         2'b01:   fold = DEG360 - angle;
         default: fold = angle;
      endcase
      wrap = (fold >= DEG360) ? fold - DEG360 : fold;
      bearing_in = side_up.axis ? side_up.axis_bearing : wrap[BEARING_W-1:0];
   end

   assign ready_up = ~valid_ff | ready_dn;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up && valid_up) begin
         bearing_ff <= bearing_in;
         bvalid_ff  <= side_up.pts_differ;
      end
   end

   assign valid_dn      = valid_ff;
   assign bearing       = bearing_ff;
   assign bearing_valid = bvalid_ff;

endmodule

>>> design/bearing_to_point_unit.sv
// ----------------------------------------------------------------------------
// bearing_to_point_unit
// bearing from a current to a target position by pipelined cordic vectoring
// ----------------------------------------------------------------------------
//  channel    dir  payload                                   handshake
//  req_chan   in   cur_x cur_y target_x target_y             valid/ready
//  rsp_chan   out  bearing[14:0] bearing_valid               valid/ready
//
//  one transaction per cycle sustained while rsp_chan is ready; the slots are
//  the front register, one cell per cordic rotation and the response register;
//  every slot has its own valid bit, so bubbles close up under a stall
//  and new transactions enter while a response waits
//  synchronous reset empties all slots
// ----------------------------------------------------------------------------
module bearing_to_point_unit import btp_pkg::*; #(
   parameter int COORD_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic      clock,
   input  logic      reset,
   btp_req_if.sink   req_chan,
   btp_rsp_if.source rsp_chan
);

   localparam int DW = COORD_WIDTH + Z_FRAC + 3;
   localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   logic                 valid_c [NS+1];
   logic                 ready_c [NS+1];
   logic signed [DW-1:0] x_c     [NS+1];
   logic signed [DW-1:0] y_c     [NS+1];
   logic signed [ZW-1:0] z_c     [NS+1];
   btp_side_type         side_c  [NS+1];

   btp_front #(.COORD_WIDTH(COORD_WIDTH), .DW(DW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .valid_up (req_chan.valid),
      .ready_up (req_chan.ready),
      .cur_x    (req_chan.cur_x),
      .cur_y    (req_chan.cur_y),
      .target_x (req_chan.target_x),
      .target_y (req_chan.target_y),
      .valid_dn (valid_c[0]),
      .ready_dn (ready_c[0]),
      .x_dn     (x_c[0]),
      .y_dn     (y_c[0]),
      .side_dn  (side_c[0])
   );

   assign z_c[0] = '0;

   for (genvar i = 0; i < NS; i++) begin : g_cell
      btp_cell #(.DW(DW), .STAGE(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_up (valid_c[i]),
         .ready_up (ready_c[i]),
         .x_up     (x_c[i]),
         .y_up     (y_c[i]),
         .z_up     (z_c[i]),
         .side_up  (side_c[i]),
         .valid_dn (valid_c[i+1]),
         .ready_dn (ready_c[i+1]),
         .x_dn     (x_c[i+1]),
         .y_dn     (y_c[i+1]),
         .z_dn     (z_c[i+1]),
         .side_dn  (side_c[i+1])
      );
   end

   btp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .valid_up      (valid_c[NS]),
      .ready_up      (ready_c[NS]),
      .z_up          (z_c[NS]),
      .side_up       (side_c[NS]),
      .valid_dn      (rsp_chan.valid),
      .ready_dn      (rsp_chan.ready),
      .bearing       (rsp_chan.bearing),
      .bearing_valid (rsp_chan.bearing_valid)
   );

endmodule

>>> design/btp_checker.sv
// ----------------------------------------------------------------------------
// btp_checker
// port-level checks of the bearing-to-point unit, bound to the top level
// ----------------------------------------------------------------------------
module btp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [14:0] rsp_bearing,
   input logic        rsp_bearing_valid
);

   localparam logic [14:0] FULL_TURN = 15'd23040;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bearing)
                                  && $stable(rsp_bearing_valid))
      else $error("response changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bearing < FULL_TURN)
      else $error("bearing out of range");

   a_coincident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bearing_valid |-> rsp_bearing == '0)
      else $error("coincident points with nonzero bearing");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bearing_to_point_unit btp_checker u_btp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_bearing       (rsp_chan.bearing),
   .rsp_bearing_valid (rsp_chan.bearing_valid)
);

>>> test/bearing_to_point_unit_tb.sv
// ----------------------------------------------------------------------------
// bearing_to_point_unit_tb
// drives position pairs through the bearing unit under random backpressure
// and checks every response against a known value or cordic vectoring model
// ----------------------------------------------------------------------------
module bearing_to_point_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W     = 16;
   localparam int STAGES      = 16;
   localparam int RANDOM_LOTS = 3;
   localparam int LOT_ITEMS   = 235;
   localparam int DRAIN       = 40;
   localparam int HOLD_CYCLES = 120;
   localparam int CYCLE_LIMIT = 200000;

   localparam longint ANG_90   = 5760;
   localparam longint ANG_180  = 11520;
   localparam longint ANG_270  = 17280;
   localparam longint ANG_360  = 23040;
   localparam longint Z_RIGHT  = 377487360;

   localparam longint ROT_ANGLE [32] = '{
      188743680, 111421900, 58872272, 29884485,
      15000234,  7507429,   3754631,  1877430,
      938729,    469366,    234683,   117342,
      58671,     29335,     14668,    7334,
      3667,      1833,      917,      458,
      229,       115,       57,       29,
      14,        7,         4,        2,
      1,         0,         0,        0
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] cur_x;
      logic signed [COORD_W-1:0] cur_y;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
   } position_pair_type;

   typedef struct packed {
      logic [14:0] bearing;
      logic        bearing_valid;
   } bearing_result_type;

   typedef struct {
      int cx;
      int cy;
      int tx;
      int ty;
      bit known;
      int bearing;
      bit bearing_valid;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   btp_req_if #(.COORD_WIDTH(COORD_W)) req_chan();
   btp_rsp_if                          rsp_chan();

   bearing_to_point_unit #(
      .COORD_WIDTH  (COORD_W),
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #2 clock = ~clock;

   bearing_result_type pending_bearings[$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 snd_idle_pct = 0;
   int                 rcv_idle_pct = 0;
   bit                 hold_request = 1'b0;

   stim_row_type directed_rows [22] = '{
      '{0, 0, 0, 0, 1, 0, 0},
      '{-32768, 32767, -32768, 32767, 1, 0, 0},
      '{-1, -1, -1, -1, 1, 0, 0},
      '{-32768, 0, 32767, 0, 1, 0, 1},
      '{32767, 5, -32768, 5, 1, 11520, 1},
      '{0, -32768, 0, 32767, 1, 5760, 1},
      '{100, 32767, 100, -32768, 1, 17280, 1},
      '{0, 0, 1, 0, 1, 0, 1},
      '{-1, -1, -1, -2, 1, 17280, 1},
      '{0, 0, 1000, 1000, 0, 0, 0},
      '{0, 0, -1000, 577, 0, 0, 0},
      '{0, 0, -300, -700, 0, 0, 0},
      '{0, 0, 700, -300, 0, 0, 0},
      '{-32768, 0, 32767, -1, 0, 0, 0},
      '{-32768, -32768, 32767, -32767, 0, 0, 0},
      '{32767, 0, -32768, 1, 0, 0, 0},
      '{32767, 0, -32768, -1, 0, 0, 0},
      '{0, -32768, 1, 32767, 0, 0, 0},
      '{0, 32767, -1, -32768, 0, 0, 0},
      '{-32768, -32768, 32767, 32767, 0, 0, 0},
      '{32767, 32767, -32768, -32768, 0, 0, 0},
      '{0, 0, 1, 1, 0, 0, 0}
   };

   function automatic bearing_result_type predict_bearing(input position_pair_type p);
      longint dx, dy, x, y, z, xs, ys, a, b;
      bearing_result_type r;
      dx = longint'(p.target_x) - longint'(p.cur_x);
      dy = longint'(p.target_y) - longint'(p.cur_y);
      b = 0;
      r.bearing_valid = 1'b1;
      if (dx == 0 && dy == 0) begin
         r.bearing_valid = 1'b0;
      end else if (dy == 0) begin
         b = (dx > 0) ? 0 : ANG_180;
      end else if (dx == 0) begin
         b = (dy > 0) ? ANG_90 : ANG_270;
      end else begin
         x = ((dx < 0) ? -dx : dx) * 65536;
         y = ((dy < 0) ? -dy : dy) * 65536;
         z = 0;
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ROT_ANGLE[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ROT_ANGLE[i];
            end
         end
         if (z < 0) z = 0;
         if (z > Z_RIGHT) z = Z_RIGHT;
         a = (z + 32768) >>> 16;
         if (dx > 0 && dy > 0) b = a;
         else if (dx < 0 && dy > 0) b = ANG_180 - a;
         else if (dx < 0) b = ANG_180 + a;
         else b = ANG_360 - a;
         if (b >= ANG_360) b = b - ANG_360;
      end
      r.bearing = b[14:0];
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] corner_coord();
      case ($urandom_range(0, 4))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic position_pair_type random_pair();
      position_pair_type p;
      int kind;
      kind = $urandom_range(0, 99);
      p.cur_x    = COORD_W'($urandom);
      p.cur_y    = COORD_W'($urandom);
      p.target_x = COORD_W'($urandom);
      p.target_y = COORD_W'($urandom);
      if (kind < 50) begin
      end else if (kind < 70) begin
         p.target_x = p.cur_x + COORD_W'(int'($urandom_range(0, 16)) - 8);
         p.target_y = p.cur_y + COORD_W'(int'($urandom_range(0, 16)) - 8);
      end else if (kind < 80) begin
         if ($urandom_range(0, 1)) p.target_x = p.cur_x;
         else p.target_y = p.cur_y;
      end else if (kind < 85) begin
         p.target_x = p.cur_x;
         p.target_y = p.cur_y;
      end else if (kind < 95) begin
         if ($urandom_range(0, 1))
            p.target_x = p.cur_x + COORD_W'(int'($urandom_range(0, 4)) - 2);
         else
            p.target_y = p.cur_y + COORD_W'(int'($urandom_range(0, 4)) - 2);
      end else begin
         p.cur_x    = corner_coord();
         p.cur_y    = corner_coord();
         p.target_x = corner_coord();
         p.target_y = corner_coord();
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_pair(input position_pair_type p, input bit known,
                            input bearing_result_type known_result);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cur_x    <= p.cur_x;
      req_chan.cur_y    <= p.cur_y;
      req_chan.target_x <= p.target_x;
      req_chan.target_y <= p.target_y;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_bearings.push_back(known ? known_result : predict_bearing(p));
   endtask

   initial begin : response_side
      bearing_result_type want;
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_bearings.size() == 0) begin
               report_mismatch("unexpected transaction, bearing", rsp_chan.bearing, -1);
            end else begin
               want = pending_bearings.pop_front();
               if (rsp_chan.bearing !== want.bearing)
                  report_mismatch("bearing", rsp_chan.bearing, want.bearing);
               if (rsp_chan.bearing_valid !== want.bearing_valid)
                  report_mismatch("bearing_valid", rsp_chan.bearing_valid,
                                  want.bearing_valid);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : request_side
      position_pair_type p;
      bearing_result_type r;
      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.cur_x    = '0;
      req_chan.cur_y    = '0;
      req_chan.target_x = '0;
      req_chan.target_y = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 16;
      rcv_idle_pct = 76;
      foreach (directed_rows[i]) begin
         p.cur_x    = COORD_W'(directed_rows[i].cx);
         p.cur_y    = COORD_W'(directed_rows[i].cy);
         p.target_x = COORD_W'(directed_rows[i].tx);
         p.target_y = COORD_W'(directed_rows[i].ty);
         r.bearing       = 15'(directed_rows[i].bearing);
         r.bearing_valid = directed_rows[i].bearing_valid;
         send_pair(p, directed_rows[i].known, r);
      end
      for (int lot = 0; lot < RANDOM_LOTS; lot++) begin
         case (lot)
            0: begin snd_idle_pct = 16; rcv_idle_pct = 76; end
            1: begin snd_idle_pct = 76; rcv_idle_pct = 16; end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
               hold_request = 1'b1;
            end
         endcase
         for (int n = 0; n < LOT_ITEMS; n++)
            send_pair(random_pair(), 1'b0, '0);
      end
      req_chan.valid <= 1'b0;
      while (pending_bearings.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
